// ===== hdl/mpk_pkg.sv =====
package mpk_pkg;

    localparam logic [3:0] K_NIL  = 4'd0;
    localparam logic [3:0] K_INT  = 4'd1;
    localparam logic [3:0] K_DBL  = 4'd2;
    localparam logic [3:0] K_BLOB = 4'd3;
    localparam logic [3:0] K_BYTE = 4'd4;
    localparam logic [3:0] K_LIST = 4'd5;
    localparam logic [3:0] K_MAP  = 4'd6;
    localparam logic [3:0] K_END  = 4'd7;
    localparam logic [3:0] K_ERR  = 4'd8;

    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_FMT   = 3'd1;
    localparam logic [2:0] E_EOS   = 3'd2;
    localparam logic [2:0] E_DEEP  = 3'd3;
    localparam logic [2:0] E_ZBLOB = 3'd4;

    localparam int CNT_W = 33;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_value;
        logic [7:0]  blob_subtype;
        logic [4:0]  nest_depth;
        logic [2:0]  error_code;
        logic        last_of_run;
    } t_out;

    function automatic logic [3:0] header_size(input logic [7:0] b);
        unique case (b)
            8'hcc, 8'hd0, 8'hc4, 8'hd9: header_size = 4'd1;
            8'hcd, 8'hd1, 8'hc5, 8'hda, 8'hdc, 8'hde: header_size = 4'd2;
            8'hca, 8'hce, 8'hd2, 8'hc6, 8'hdb, 8'hdd, 8'hdf: header_size = 4'd4;
            8'hcb, 8'hcf, 8'hd3: header_size = 4'd8;
            default: header_size = 4'd0;
        endcase
    endfunction

    function automatic logic [63:0] widen_float(input logic [31:0] f);
        logic [7:0]  e;
        logic [22:0] m;
        logic [4:0]  p;
        logic [51:0] mm;
        e = f[30:23];
        m = f[22:0];
        p = 5'd0;
        for (int i = 0; i < 23; i++) begin
            if (m[i]) p = 5'(i);
        end
        mm = 52'({29'd0, m} << (6'd52 - {1'b0, p}));
        if (e == 8'hff)
            widen_float = {f[31], 11'h7ff, m, 29'd0};
        else if (e == 8'd0)
            widen_float = (m == 23'd0) ? {f[31], 63'd0}
                : {f[31], 11'({6'd0, p} + 11'd874), mm};
        else
            widen_float = {f[31], 11'({3'd0, e} + 11'd896), m, 29'd0};
    endfunction

endpackage

// ===== hdl/mpk_if.sv =====
interface mpk_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/msgpack_stream_tokenizer.sv =====
// A token leaves through the output register after its byte is registered
// and decoded; each container end that follows waits for the output
// register, then does the stack read, decrement and write back.
// A byte is accepted only when idle with the output register empty, so a
// byte and the container ends it closes finish before the next is taken.
// Synchronous active-low reset returns to the format-byte phase, empty stack.
module msgpack_stream_tokenizer
    import mpk_pkg::*;
#(
    parameter int MAX_DEPTH = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mpk_if.sink   i_in,
    mpk_if.source o_out
);
    localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int SW = $clog2(MAX_DEPTH + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_POP  = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    typedef enum logic [1:0] {PH_FORMAT, PH_VALUE, PH_SUBTYPE, PH_DATA} t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic [7:0]  r_fmt, n_fmt;
    logic [63:0] r_acc, n_acc;
    logic [31:0] r_rem, n_rem;
    logic [SW-1:0] r_sp, n_sp;
    t_in   r_in;
    t_out  r_out, n_out;
    logic  r_ov, n_ov;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [CNT_W-1:0]  wdata, rdata, dec;

    mpk_ram #(.WIDTH(CNT_W), .DEPTH(MAX_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign i_in.ready  = (r_state == ST_IDLE) && !r_ov;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    logic [SW-1:0] sp_m1;
    assign sp_m1 = r_sp - SW'(1);
    assign raddr = AW'(sp_m1);
    assign dec   = rdata - CNT_W'(1);

    function automatic t_out mk(input logic [3:0] k, input logic [63:0] v,
                                input logic [7:0] s, input logic [SW-1:0] d,
                                input logic [2:0] e, input logic l);
        t_out o;
        o.token_kind = k; o.token_value = v; o.blob_subtype = s;
        o.nest_depth = 5'(d); o.error_code = e; o.last_of_run = l;
        return o;
    endfunction

    always_comb begin
        logic [7:0]  b;
        logic [63:0] a, v;
        logic [3:0]  hs;
        logic        is_cont, is_map, do_val, do_blob, do_close;
        logic [63:0] blen;
        logic [CNT_W-1:0] elems;
        logic [3:0]  vk;
        n_state = r_state; n_phase = r_phase; n_fmt = r_fmt; n_acc = r_acc;
        n_rem = r_rem; n_sp = r_sp; n_out = r_out; n_ov = r_ov;
        we = 1'b0; waddr = AW'(r_sp); wdata = '0;
        b = r_in.data_byte;
        a = {r_acc[55:0], b};
        hs = header_size(b);
        is_cont = 1'b0; is_map = 1'b0; do_val = 1'b0; do_blob = 1'b0; do_close = 1'b0;
        blen = '0; elems = '0; vk = K_INT; v = '0;
        if (r_ov && o_out.ready) n_ov = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in.valid && i_in.ready) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                if (r_in.end_of_stream) begin
                    if (r_phase != PH_FORMAT || r_sp != '0) begin
                        n_out = mk(K_ERR, '0, '0, '0, E_EOS, 1'b1);
                        n_ov = 1'b1; n_sp = '0; n_phase = PH_FORMAT;
                    end
                end else begin
                    unique case (r_phase)
                        PH_VALUE: begin
                            n_acc = a;
                            n_rem = r_rem - 32'd1;
                            if (r_rem == 32'd1) begin
                                priority case (r_fmt)
                                    8'hca: begin
                                        do_val = 1'b1; vk = K_DBL;
                                        v = widen_float(a[31:0]);
                                    end
                                    8'hcb: begin do_val = 1'b1; vk = K_DBL; v = a; end
                                    8'hcc, 8'hcd, 8'hce, 8'hcf, 8'hd3: begin
                                        do_val = 1'b1; v = a;
                                    end
                                    8'hd0: begin do_val = 1'b1; v = 64'(signed'(a[7:0])); end
                                    8'hd1: begin do_val = 1'b1; v = 64'(signed'(a[15:0])); end
                                    8'hd2: begin do_val = 1'b1; v = 64'(signed'(a[31:0])); end
                                    8'hdc, 8'hdd: begin
                                        is_cont = 1'b1; v = a; elems = CNT_W'(a);
                                    end
                                    8'hde, 8'hdf: begin
                                        is_cont = 1'b1; is_map = 1'b1; v = a;
                                        elems = {a[31:0], 1'b0};
                                    end
                                    default: begin do_blob = 1'b1; blen = a; end
                                endcase
                            end
                        end
                        PH_SUBTYPE: begin
                            n_out = mk(K_BLOB, 64'(r_rem), b, r_sp, E_NONE, 1'b1);
                            n_ov = 1'b1;
                            if (r_rem == '0) begin
                                n_phase = PH_FORMAT;
                                do_close = 1'b1;
                            end else n_phase = PH_DATA;
                        end
                        PH_DATA: begin
                            n_rem = r_rem - 32'd1;
                            n_out = mk(K_BYTE, 64'(b), '0, r_sp, E_NONE, 1'b1);
                            n_ov = 1'b1;
                            if (r_rem == 32'd1) begin
                                n_phase = PH_FORMAT;
                                do_close = 1'b1;
                            end
                        end
                        default: begin
                            if (b < 8'h80) begin do_val = 1'b1; v = 64'(b); end
                            else if (b >= 8'he0) begin
                                do_val = 1'b1; v = {56'hffffffffffffff, b};
                            end else if ((b & 8'hf0) == 8'h80) begin
                                is_cont = 1'b1; is_map = 1'b1; v = 64'(b & 8'h0f);
                                elems = CNT_W'({b & 8'h0f, 1'b0});
                            end else if ((b & 8'hf0) == 8'h90) begin
                                is_cont = 1'b1; v = 64'(b & 8'h0f);
                                elems = CNT_W'(b & 8'h0f);
                            end else if ((b & 8'he0) == 8'ha0) begin
                                do_blob = 1'b1; blen = 64'(b & 8'h1f);
                            end else if (b == 8'hc0) begin do_val = 1'b1; vk = K_NIL; end
                            else if (b == 8'hc2) begin do_val = 1'b1; end
                            else if (b == 8'hc3) begin do_val = 1'b1; v = 64'd1; end
                            else if (hs == 4'd0) begin
                                n_out = mk(K_ERR, '0, '0, '0, E_FMT, 1'b1);
                                n_ov = 1'b1; n_sp = '0;
                            end else begin
                                n_fmt = b; n_acc = '0; n_rem = 32'(hs);
                                n_phase = PH_VALUE;
                            end
                        end
                    endcase
                    if (do_val) begin
                        n_out = mk(vk, v, '0, r_sp, E_NONE, 1'b1);
                        n_ov = 1'b1; n_phase = PH_FORMAT;
                        do_close = 1'b1;
                    end
                    if (do_blob) begin
                        if (blen == '0) begin
                            n_out = mk(K_ERR, '0, '0, '0, E_ZBLOB, 1'b1);
                            n_ov = 1'b1; n_sp = '0; n_phase = PH_FORMAT;
                        end else begin
                            n_rem = 32'(blen - 64'd1); n_phase = PH_SUBTYPE;
                        end
                    end
                    if (is_cont) begin
                        n_phase = PH_FORMAT;
                        if (r_sp >= SW'(MAX_DEPTH)) begin
                            n_out = mk(K_ERR, '0, '0, '0, E_DEEP, 1'b1);
                            n_ov = 1'b1; n_sp = '0;
                        end else begin
                            n_out = mk(is_map ? K_MAP : K_LIST, v, '0, r_sp, E_NONE,
                                       1'b0);
                            n_ov = 1'b1;
                            if (elems == '0) begin
                                n_state = ST_EMIT;
                            end else begin
                                n_out.last_of_run = 1'b1;
                                we = 1'b1; waddr = AW'(r_sp); wdata = elems;
                                n_sp = r_sp + SW'(1);
                            end
                        end
                    end
                end
            end
            ST_EMIT: begin
                // a token waits in r_out; once taken, emit the next end
                if (!r_ov || o_out.ready) n_state = ST_POP;
            end
            ST_POP: begin
                n_out = mk(K_END, '0, '0, r_sp, E_NONE, 1'b1);
                n_ov = 1'b1; n_state = ST_IDLE;
                do_close = 1'b1;
            end
            default: n_state = ST_IDLE;
        endcase
        // count the finished value at the enclosing level; zero closes it
        if (do_close && r_sp != '0) begin
            we = 1'b1; waddr = raddr; wdata = dec;
            if (dec == '0) begin
                n_out.last_of_run = 1'b0;
                n_sp = sp_m1; n_state = ST_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_FORMAT;
            r_fmt <= '0;
            r_acc <= '0;
            r_rem <= '0;
            r_sp <= '0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_fmt <= n_fmt;
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_sp <= n_sp;
            r_ov <= n_ov;
        end
        r_out <= n_out;
        if (i_in.valid && i_in.ready) r_in <= i_in.data;
    end
endmodule

// ===== hdl/mpk_ram.sv =====
module mpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
